// ===== hdl/msp_pkg.sv =====
// Shared types and constants for the matrix saddle point finder.
package msp_pkg;

   localparam int ELEM_W    = 32;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int OUT_IDX_W = 3;

   localparam logic [CFG_W-1:0] ROW_COUNT_RESET = 4'd2;
   localparam logic [CFG_W-1:0] COL_COUNT_RESET = 4'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROW_COUNT = 2'd0,
      CSR_COL_COUNT = 2'd1
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_LOAD  = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   typedef struct packed {
      logic capture;
      logic load_write;
      logic scan_init;
      logic scan_step;
      logic scan_sel;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic load_last;
      logic scan_last;
      logic rsp_free;
   } status_type;

endpackage

// ===== hdl/msp_ctrl.sv =====
// Control state machine of the matrix saddle point finder.
module msp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  msp_pkg::status_type status,
   output msp_pkg::cmd_type    cmd
);

   msp_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         msp_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = msp_pkg::ST_LOAD;
            end
         end
         msp_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
            if (status.load_last) begin
               cmd.scan_init = 1'b1;
               state_in      = msp_pkg::ST_SCAN;
            end else begin
               state_in = msp_pkg::ST_IDLE;
            end
         end
         msp_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.scan_sel  = 1'b1;
            if (status.scan_last) begin
               state_in = msp_pkg::ST_DRAIN;
            end
         end
         msp_pkg::ST_DRAIN: begin
            // The compare of the last element finishes here.
            state_in = msp_pkg::ST_EMIT;
         end
         msp_pkg::ST_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = msp_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = msp_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= msp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/msp_dp.sv =====
// Datapath of the matrix saddle point finder: registers, stores, scan compare, result register.
module msp_dp #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [msp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [msp_pkg::CFG_W-1:0]            csr_wdata,
   input  logic signed [msp_pkg::ELEM_W-1:0]    element_value,
   input  msp_pkg::cmd_type                     cmd,
   output msp_pkg::status_type                  status,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic                                 rsp_found,
   output logic signed [msp_pkg::ELEM_W-1:0]    rsp_saddle_value,
   output logic [msp_pkg::OUT_IDX_W-1:0]        rsp_saddle_row,
   output logic [msp_pkg::OUT_IDX_W-1:0]        rsp_saddle_col
);

   localparam int DEPTH = MAX_ROWS * MAX_COLS;
   localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CIW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // Configuration registers.
   logic [msp_pkg::CFG_W-1:0] row_count_ff, row_count_in;
   logic [msp_pkg::CFG_W-1:0] col_count_ff, col_count_in;
   logic                      cfg_hit;
   logic [RIW-1:0]            rows_last;
   logic [CIW-1:0]            cols_last;

   // Load position.
   logic [RIW-1:0] load_r_ff, load_r_in;
   logic [CIW-1:0] load_c_ff, load_c_in;
   logic           pos_bad;
   logic [RIW-1:0] eff_r;
   logic [CIW-1:0] eff_c;
   logic [AW-1:0]  load_addr;

   logic signed [msp_pkg::ELEM_W-1:0] elem_ff;

   // Stores with registered reads.
   logic signed [msp_pkg::ELEM_W-1:0] elem_mem    [DEPTH];
   logic signed [msp_pkg::ELEM_W-1:0] row_min_mem [MAX_ROWS];
   logic signed [msp_pkg::ELEM_W-1:0] col_max_mem [MAX_COLS];
   logic signed [msp_pkg::ELEM_W-1:0] elem_rd_ff;
   logic signed [msp_pkg::ELEM_W-1:0] row_min_rd_ff;
   logic signed [msp_pkg::ELEM_W-1:0] col_max_rd_ff;
   logic signed [msp_pkg::ELEM_W-1:0] row_min_new;
   logic signed [msp_pkg::ELEM_W-1:0] col_max_new;
   logic [RIW-1:0]                    mm_r;
   logic [CIW-1:0]                    mm_c;

   // Scan position and compare stage.
   logic [RIW-1:0] scan_r_ff, scan_r_in;
   logic [CIW-1:0] scan_c_ff, scan_c_in;
   logic [AW-1:0]  scan_addr;
   logic           tag_valid_ff;
   logic [RIW-1:0] tag_r_ff;
   logic [CIW-1:0] tag_c_ff;
   logic           match;
   logic           take;
   logic           row_hit_ff, row_hit_in;

   logic                              found_ff;
   logic signed [msp_pkg::ELEM_W-1:0] sv_ff;
   logic [RIW-1:0]                    sr_ff;
   logic [CIW-1:0]                    sc_ff;

   logic                              rsp_valid_ff;
   logic                              rsp_found_ff;
   logic signed [msp_pkg::ELEM_W-1:0] rsp_value_ff;
   logic [msp_pkg::OUT_IDX_W-1:0]     rsp_row_ff;
   logic [msp_pkg::OUT_IDX_W-1:0]     rsp_col_ff;

   // Dimensions: zero counts as one, anything above the maximum as the maximum.
   always_comb begin
      if (row_count_ff == '0) begin
         rows_last = '0;
      end else if (32'(row_count_ff) > MAX_ROWS) begin
         rows_last = RIW'(MAX_ROWS - 1);
      end else begin
         rows_last = RIW'(row_count_ff - 1'b1);
      end
      if (col_count_ff == '0) begin
         cols_last = '0;
      end else if (32'(col_count_ff) > MAX_COLS) begin
         cols_last = CIW'(MAX_COLS - 1);
      end else begin
         cols_last = CIW'(col_count_ff - 1'b1);
      end
   end

   always_comb begin
      pos_bad   = (load_r_ff > rows_last) || (load_c_ff > cols_last);
      eff_r     = pos_bad ? '0 : load_r_ff;
      eff_c     = pos_bad ? '0 : load_c_ff;
      load_addr = AW'(32'(eff_r) * MAX_COLS + 32'(eff_c));
      scan_addr = AW'(32'(scan_r_ff) * MAX_COLS + 32'(scan_c_ff));
      mm_r      = cmd.scan_sel ? scan_r_ff : eff_r;
      mm_c      = cmd.scan_sel ? scan_c_ff : eff_c;
   end

   always_comb begin
      cfg_hit      = 1'b0;
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (csr_valid) begin
         case (csr_index)
            msp_pkg::CSR_ROW_COUNT: begin
               row_count_in = csr_wdata;
               cfg_hit      = 1'b1;
            end
            msp_pkg::CSR_COL_COUNT: begin
               col_count_in = csr_wdata;
               cfg_hit      = 1'b1;
            end
            default: begin
               cfg_hit = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      load_r_in = load_r_ff;
      load_c_in = load_c_ff;
      if (cfg_hit) begin
         load_r_in = '0;
         load_c_in = '0;
      end else if (cmd.load_write) begin
         if (eff_c == cols_last) begin
            load_c_in = '0;
            load_r_in = (eff_r == rows_last) ? '0 : eff_r + 1'b1;
         end else begin
            load_r_in = eff_r;
            load_c_in = eff_c + 1'b1;
         end
      end
   end

   // The first element of a row or column starts its running extreme.
   always_comb begin
      row_min_new = ((eff_c == '0) || (elem_ff < row_min_rd_ff)) ? elem_ff : row_min_rd_ff;
      col_max_new = ((eff_r == '0) || (elem_ff > col_max_rd_ff)) ? elem_ff : col_max_rd_ff;
   end

   always_comb begin
      scan_r_in = scan_r_ff;
      scan_c_in = scan_c_ff;
      if (cmd.scan_init) begin
         scan_r_in = '0;
         scan_c_in = '0;
      end else if (cmd.scan_step) begin
         if (scan_c_ff == cols_last) begin
            scan_c_in = '0;
            scan_r_in = scan_r_ff + 1'b1;
         end else begin
            scan_c_in = scan_c_ff + 1'b1;
         end
      end
   end

   // Within a row only the first hit counts; a later row overrides an earlier one.
   always_comb begin
      match      = (elem_rd_ff == row_min_rd_ff) && (elem_rd_ff == col_max_rd_ff);
      take       = tag_valid_ff && match && ((tag_c_ff == '0) || !row_hit_ff);
      row_hit_in = row_hit_ff;
      if (tag_valid_ff) begin
         row_hit_in = ((tag_c_ff == '0) ? 1'b0 : row_hit_ff) | match;
      end
   end

   always_comb begin
      status.load_last = (eff_r == rows_last) && (eff_c == cols_last);
      status.scan_last = (scan_r_ff == rows_last) && (scan_c_ff == cols_last);
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= msp_pkg::ROW_COUNT_RESET;
         col_count_ff <= msp_pkg::COL_COUNT_RESET;
         load_r_ff    <= '0;
         load_c_ff    <= '0;
         scan_r_ff    <= '0;
         scan_c_ff    <= '0;
         tag_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
         load_r_ff    <= load_r_in;
         load_c_ff    <= load_c_in;
         scan_r_ff    <= scan_r_in;
         scan_c_ff    <= scan_c_in;
         tag_valid_ff <= cmd.scan_step;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      elem_rd_ff    <= elem_mem[scan_addr];
      row_min_rd_ff <= row_min_mem[mm_r];
      col_max_rd_ff <= col_max_mem[mm_c];
      if (cmd.load_write) begin
         elem_mem[load_addr] <= elem_ff;
         row_min_mem[eff_r]  <= row_min_new;
         col_max_mem[eff_c]  <= col_max_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         elem_ff <= element_value;
      end
      tag_r_ff   <= scan_r_ff;
      tag_c_ff   <= scan_c_ff;
      row_hit_ff <= row_hit_in;
      if (cmd.scan_init) begin
         found_ff <= 1'b0;
         sv_ff    <= '0;
         sr_ff    <= '0;
         sc_ff    <= '0;
      end else if (take) begin
         found_ff <= 1'b1;
         sv_ff    <= elem_rd_ff;
         sr_ff    <= tag_r_ff;
         sc_ff    <= tag_c_ff;
      end
      if (cmd.emit) begin
         rsp_found_ff <= found_ff;
         rsp_value_ff <= sv_ff;
         rsp_row_ff   <= msp_pkg::OUT_IDX_W'(sr_ff);
         rsp_col_ff   <= msp_pkg::OUT_IDX_W'(sc_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_saddle_value = rsp_value_ff;
   assign rsp_saddle_row   = rsp_row_ff;
   assign rsp_saddle_col   = rsp_col_ff;

endmodule

// ===== hdl/matrix_saddle_point_finder.sv =====
// Loading an element is an accept, then a read-modify-write of the row and column extremes.
// After the last element of an N-element matrix is accepted, the scan rereads the element store
// one entry per cycle; the result is registered after the scan, a drain state and the emit state.
// Emit waits while an earlier result is not taken; a pending result does not block the next load.
// Reset (synchronous, active high) sets row_count to 2, col_count to 3 and the load position to 0;
// the element store and the row and column extremes are not cleared, as no stale entry is read.
module matrix_saddle_point_finder #(
   parameter int MAX_ROWS = 8,
   parameter int MAX_COLS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [msp_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [msp_pkg::CFG_W-1:0]            csr_wdata,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [msp_pkg::ELEM_W-1:0]    req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic signed [msp_pkg::ELEM_W-1:0]    rsp_saddle_value,
   output logic [msp_pkg::OUT_IDX_W-1:0]        rsp_saddle_row,
   output logic [msp_pkg::OUT_IDX_W-1:0]        rsp_saddle_col
);

   msp_pkg::cmd_type    cmd;
   msp_pkg::status_type status;

   assign csr_ready = 1'b1;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   msp_dp #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .element_value    (req_element_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_saddle_value (rsp_saddle_value),
      .rsp_saddle_row   (rsp_saddle_row),
      .rsp_saddle_col   (rsp_saddle_col)
   );

   // Each accepted transaction is followed by its update cycle, so no second accept can follow.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted in the update cycle of the previous element");

   // A result without a saddle point carries all-zero fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |->
         (rsp_saddle_value == '0 && rsp_saddle_row == '0 && rsp_saddle_col == '0))
      else $error("result without a saddle point has nonzero fields");

   // Issuing a result returns the controller to loading.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> req_ready)
      else $error("controller not ready for loading after issuing a result");

endmodule
